### rtl/dlri_pkg.sv
`timescale 1ns / 1ps

package dlri_pkg;

  // Parser phases of the front part.
  localparam logic [2:0] PH_FILEHDR = 3'd0;
  localparam logic [2:0] PH_EXTRA   = 3'd1;
  localparam logic [2:0] PH_LEAD    = 3'd2;
  localparam logic [2:0] PH_ENTRY   = 3'd3;
  localparam logic [2:0] PH_SIZE    = 3'd4;
  localparam logic [2:0] PH_TIME    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;

  // The file header is 12 bytes; its last four bytes give the extra header length.
  localparam logic [3:0] FILE_HEADER_LAST = 4'd11;
  localparam logic [3:0] EXTRA_LEN_FIRST  = 4'd8;

  // Entry id of control records, which do not count toward the timestamp range.
  localparam logic [31:0] CTRL_ENTRY_ID = 32'd0;

  // Result kinds.
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One input word: a byte of the log file.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  // One output word: a record index entry or the end-of-file summary.
  typedef struct packed {
    logic               kind;
    logic [31:0]        entry_id;
    logic [31:0]        record_offset;
    logic [31:0]        record_count;
    logic signed [63:0] min_timestamp;
    logic signed [63:0] max_timestamp;
    logic               run_last;
  } out_word_t;

  // Event passed from the parser to the result stage.
  typedef struct packed {
    logic        rec_valid;
    logic        eof;
    logic [31:0] entry_id;
    logic [31:0] record_offset;
    logic [63:0] timestamp;
  } event_t;

endpackage

### rtl/dlri_fifo.sv
`timescale 1ns / 1ps

module dlri_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/dlri_front.sv
`timescale 1ns / 1ps

module dlri_front #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  dlri_pkg::in_word_t in_data,
  output logic              ev_push,
  output dlri_pkg::event_t  ev
);

  import dlri_pkg::*;

  logic [OFFSET_WIDTH-1:0] byte_position, byte_position_next;
  logic [2:0]              parse_phase, parse_phase_next;
  logic [3:0]              field_byte_index, field_byte_index_next;
  logic [7:0]              lead_byte, lead_byte_next;
  logic [31:0]             skip_remaining, skip_remaining_next;
  logic [31:0]             entry_accumulator, entry_accumulator_next;
  logic [63:0]             time_accumulator, time_accumulator_next;
  logic [31:0]             record_start, record_start_next;
  logic [63:0]             finish_time;
  logic [31:0]             skip_dec;
  logic                    finish;
  logic [7:0]              b;

  assign b        = in_data.data_byte;
  assign skip_dec = skip_remaining - 32'd1;

  // Byte-by-byte parse of headers and record fields.
  always_comb begin
    byte_position_next     = byte_position;
    parse_phase_next       = parse_phase;
    field_byte_index_next  = field_byte_index;
    lead_byte_next         = lead_byte;
    skip_remaining_next    = skip_remaining;
    entry_accumulator_next = entry_accumulator;
    time_accumulator_next  = time_accumulator;
    record_start_next      = record_start;
    finish_time            = time_accumulator;
    finish                 = 1'b0;
    if (fire) begin
      unique case (parse_phase)
        PH_FILEHDR: begin
          if (field_byte_index >= EXTRA_LEN_FIRST) begin
            skip_remaining_next = skip_remaining
                                  | (32'(b) << {field_byte_index[1:0], 3'b000});
          end
          field_byte_index_next = field_byte_index + 4'd1;
          if (field_byte_index == FILE_HEADER_LAST) begin
            field_byte_index_next = '0;
            parse_phase_next = (skip_remaining_next != '0) ? PH_EXTRA : PH_LEAD;
          end
        end
        PH_EXTRA: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            parse_phase_next = PH_LEAD;
          end
        end
        PH_ENTRY: begin
          entry_accumulator_next = entry_accumulator
                                   | (32'(b) << {field_byte_index[1:0], 3'b000});
          field_byte_index_next = field_byte_index + 4'd1;
          if (field_byte_index >= {2'b00, lead_byte[1:0]}) begin
            field_byte_index_next = '0;
            parse_phase_next = PH_SIZE;
          end
        end
        PH_SIZE: begin
          skip_remaining_next = skip_remaining
                                | (32'(b) << {field_byte_index[1:0], 3'b000});
          field_byte_index_next = field_byte_index + 4'd1;
          if (field_byte_index >= {2'b00, lead_byte[3:2]}) begin
            field_byte_index_next = '0;
            parse_phase_next = PH_TIME;
          end
        end
        PH_TIME: begin
          time_accumulator_next = time_accumulator
                                  | (64'(b) << {field_byte_index[2:0], 3'b000});
          field_byte_index_next = field_byte_index + 4'd1;
          if (field_byte_index >= {1'b0, lead_byte[6:4]}) begin
            field_byte_index_next = '0;
            if (skip_remaining == '0) begin
              finish = 1'b1;
              parse_phase_next = PH_LEAD;
            end else begin
              parse_phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            finish = 1'b1;
            parse_phase_next = PH_LEAD;
          end
        end
        default: begin
          // Lead byte of a record; unused phase codes land here as well.
          lead_byte_next         = b;
          record_start_next      = 32'(byte_position);
          field_byte_index_next  = '0;
          entry_accumulator_next = '0;
          skip_remaining_next    = '0;
          time_accumulator_next  = '0;
          parse_phase_next       = PH_ENTRY;
        end
      endcase
      // The finished timestamp is taken before the end of the file clears it.
      finish_time = time_accumulator_next;
      byte_position_next = byte_position + 1'b1;
      // The last byte of a file returns the parser to its reset state.
      if (in_data.end_of_file) begin
        byte_position_next     = '0;
        parse_phase_next       = PH_FILEHDR;
        field_byte_index_next  = '0;
        lead_byte_next         = '0;
        skip_remaining_next    = '0;
        entry_accumulator_next = '0;
        time_accumulator_next  = '0;
        record_start_next      = '0;
      end
    end
  end

  // Event handed to the result stage.
  always_comb begin
    ev.rec_valid     = finish;
    ev.eof           = in_data.end_of_file;
    ev.entry_id      = entry_accumulator;
    ev.record_offset = record_start;
    ev.timestamp     = finish_time;
    ev_push          = fire && (finish || in_data.end_of_file);
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      parse_phase       <= PH_FILEHDR;
      field_byte_index  <= '0;
      lead_byte         <= '0;
      skip_remaining    <= '0;
      entry_accumulator <= '0;
      time_accumulator  <= '0;
      record_start      <= '0;
    end else begin
      byte_position     <= byte_position_next;
      parse_phase       <= parse_phase_next;
      field_byte_index  <= field_byte_index_next;
      lead_byte         <= lead_byte_next;
      skip_remaining    <= skip_remaining_next;
      entry_accumulator <= entry_accumulator_next;
      time_accumulator  <= time_accumulator_next;
      record_start      <= record_start_next;
    end
  end

endmodule

### rtl/dlri_back.sv
`timescale 1ns / 1ps

module dlri_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  input  dlri_pkg::event_t    ev,
  output logic                ev_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output dlri_pkg::out_word_t out_data
);

  import dlri_pkg::*;

  logic               rec_sent, rec_sent_next;
  logic               seen_timestamp, seen_timestamp_next;
  logic signed [63:0] lowest_time, lowest_time_next;
  logic signed [63:0] highest_time, highest_time_next;
  logic [31:0]        records_done, records_done_next;
  logic               load;
  logic               emit;
  out_word_t          word_next;
  logic signed [63:0] ts;

  assign load = !out_valid || out_ready;
  assign ts   = $signed(ev.timestamp);

  // Turn each event into one or two words and keep the running statistics.
  always_comb begin
    rec_sent_next       = rec_sent;
    seen_timestamp_next = seen_timestamp;
    lowest_time_next    = lowest_time;
    highest_time_next   = highest_time;
    records_done_next   = records_done;
    word_next           = '0;
    emit                = 1'b0;
    ev_pop              = 1'b0;
    if (ev_valid && load) begin
      emit = 1'b1;
      if (ev.rec_valid && !rec_sent) begin
        word_next.kind          = KIND_RECORD;
        word_next.entry_id      = ev.entry_id;
        word_next.record_offset = ev.record_offset;
        word_next.run_last      = !ev.eof;
        records_done_next       = records_done + 32'd1;
        if (ev.entry_id != CTRL_ENTRY_ID) begin
          if (!seen_timestamp || (ts < lowest_time)) begin
            lowest_time_next = ts;
          end
          if (!seen_timestamp || (highest_time < ts)) begin
            highest_time_next = ts;
          end
          seen_timestamp_next = 1'b1;
        end
        // A record on the last byte keeps the event for the summary word.
        if (ev.eof) begin
          rec_sent_next = 1'b1;
        end else begin
          ev_pop = 1'b1;
        end
      end else begin
        word_next.kind          = KIND_SUMMARY;
        word_next.record_count  = records_done;
        word_next.min_timestamp = seen_timestamp ? lowest_time : '0;
        word_next.max_timestamp = seen_timestamp ? highest_time : '0;
        word_next.run_last      = 1'b1;
        rec_sent_next           = 1'b0;
        seen_timestamp_next     = 1'b0;
        lowest_time_next        = '0;
        highest_time_next       = '0;
        records_done_next       = '0;
        ev_pop                  = 1'b1;
      end
    end
  end

  // Statistics and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_sent       <= 1'b0;
      seen_timestamp <= 1'b0;
      lowest_time    <= '0;
      highest_time   <= '0;
      records_done   <= '0;
      out_valid      <= 1'b0;
    end else begin
      rec_sent       <= rec_sent_next;
      seen_timestamp <= seen_timestamp_next;
      lowest_time    <= lowest_time_next;
      highest_time   <= highest_time_next;
      records_done   <= records_done_next;
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= word_next;
    end
  end

endmodule

### rtl/data_log_record_indexer_unit.sv
`timescale 1ns / 1ps

// Streaming indexer for a record-structured log file.
// The input channel (in_valid, in_ready, in_data) takes one file byte per word,
// with end_of_file set on the final byte. The output channel (out_valid,
// out_ready, out_data) gives one word per completed record (kind 0: entry id
// and lead-byte offset) and one summary word after the final byte (kind 1:
// record count and the timestamp range of non-control records).
// A byte is taken every cycle while the four-entry event queue between the
// parser and the result stage has room. Each result word is built from the
// event at the queue head and held in the output register; a byte that both
// ends a record and ends the file gives its record word and then its summary
// word. The result stage gives one word per cycle while the receiver is
// ready, so the queue fills only when records end closer together than the
// receiver drains them, or while the receiver stalls; then in_ready drops.
// After the final byte the parser starts over for a new file at once.
// Reset clears the parser, the queue and the statistics and empties the output
// register; no clearing pass is needed.
module data_log_record_indexer_unit #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlri_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlri_pkg::out_word_t out_data
);

  import dlri_pkg::*;

  logic   fire;
  logic   ev_push;
  event_t ev_in;
  event_t ev_head;
  logic   ev_valid;
  logic   ev_pop;

  assign fire = in_valid && in_ready;

  // Parser.
  dlri_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_data (in_data),
    .ev_push (ev_push),
    .ev      (ev_in)
  );

  // Event queue between parser and result stage.
  dlri_fifo #(
    .WIDTH($bits(event_t)),
    .DEPTH(4)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev_in),
    .not_full  (in_ready),
    .pop       (ev_pop),
    .head_data (ev_head),
    .not_empty (ev_valid)
  );

  // Result stage.
  dlri_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev        (ev_head),
    .ev_pop    (ev_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
